FILE: sv/cpra_pkg.sv
package cpra_pkg;

    // bitmap word geometry: one bit per page, 32 pages per word
    localparam int WORD_BITS  = 32;
    localparam int OFF_W      = 5;
    localparam int IDX_W      = 13;
    localparam int WIDX_W     = IDX_W - OFF_W;
    localparam int ADDR_W     = 32;
    localparam int PAGE_SHIFT = 12;
    localparam int FIRST_W    = ADDR_W - PAGE_SHIFT;
    localparam int CFG_IDX_W  = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGES = 1'b1;

    // request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // register reset values
    localparam logic [ADDR_W-1:0] BASE_RESET  = 32'hC010_0000;
    localparam logic [IDX_W-1:0]  PAGES_RESET = 13'd4096;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE,
        S_MARK_RD,
        S_MARK_WR
    } t_state;

    // result of scanning one bitmap word
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] start;
        logic [IDX_W-1:0] run;
    } t_scan_res;

endpackage

FILE: sv/cpra_ram.sv
module cpra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/cpra_scan.sv
module cpra_scan (
    input  logic [cpra_pkg::WORD_BITS-1:0] i_word,
    input  logic [cpra_pkg::WIDX_W-1:0]    i_widx,
    input  logic [cpra_pkg::IDX_W-1:0]     i_limit,
    input  logic [cpra_pkg::IDX_W-1:0]     i_count,
    input  logic [cpra_pkg::IDX_W-1:0]     i_run,
    output cpra_pkg::t_scan_res            o_res
);

    localparam int W  = cpra_pkg::WORD_BITS;
    localparam int OW = cpra_pkg::OFF_W;
    localparam int IW = cpra_pkg::IDX_W;

    logic [W-1:0]  used;
    logic [W-1:0]  seen;
    logic [OW-1:0] last [W];
    logic [IW:0]   run  [W];
    logic [W-1:0]  fit;
    logic          any;
    logic [OW-1:0] sel;
    logic [IW:0]   start_w;

    // treat pages past the managed range as used
    always_comb begin
        for (int j = 0; j < W; j++) begin
            used[j] = i_word[j] | ({i_widx, OW'(j)} >= i_limit);
        end
    end

    // find the last used page at or below each bit
    always_comb begin
        for (int j = 0; j < W; j++) begin
            seen[j] = 1'b0;
            last[j] = '0;
            for (int k = 0; k <= j; k++) begin
                if (used[k]) begin
                    seen[j] = 1'b1;
                    last[j] = OW'(k);
                end
            end
        end
    end

    // free-run length ending at each bit, carrying the run from earlier words
    always_comb begin
        for (int j = 0; j < W; j++) begin
            if (seen[j]) begin
                run[j] = (IW+1)'(j) - (IW+1)'(last[j]);
            end else begin
                run[j] = (IW+1)'(i_run) + (IW+1)'(j + 1);
            end
            fit[j] = !used[j] && (run[j] >= {1'b0, i_count});
        end
    end

    // pick the lowest bit where the run reaches the count
    always_comb begin
        any = 1'b0;
        sel = '0;
        for (int j = W - 1; j >= 0; j--) begin
            if (fit[j]) begin
                any = 1'b1;
                sel = OW'(j);
            end
        end
        start_w = {1'b0, i_widx, sel} + (IW+1)'(1) - {1'b0, i_count};
        o_res.hit   = any;
        o_res.start = start_w[IW-1:0];
        o_res.run   = run[W-1][IW-1:0];
    end

endmodule

FILE: sv/contiguous_page_run_allocator.sv
// First-fit page-run allocator over an occupancy bitmap kept in one RAM,
// 32 pages per word. Pulse start while busy is low; the result comes back
// as a one-cycle o_strobe with o_run_address and o_ok and cannot be held
// off. An allocate reads one bitmap word per cycle through the RAM's single
// read port until the run is found, then does a read-modify-write of each
// bitmap word that the run touches to mark it. A free first clips its range,
// then clears each word that the clipped run touches the same way. A zero-count
// or oversized allocate answers in the cycle after start. After reset the block
// stays busy while it clears the bitmap; configuration writes are taken at any
// time but must only be issued while busy is low and no result is pending.
module contiguous_page_run_allocator #(
    parameter int NUM_PAGES = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_op,
    input  logic [cpra_pkg::IDX_W-1:0]        i_page_count,
    input  logic [cpra_pkg::ADDR_W-1:0]       i_address,
    output logic                              o_strobe,
    output logic [cpra_pkg::ADDR_W-1:0]       o_run_address,
    output logic                              o_ok,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cpra_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cpra_pkg::ADDR_W-1:0]       i_cfg_data
);

    localparam int W     = cpra_pkg::WORD_BITS;
    localparam int IW    = cpra_pkg::IDX_W;
    localparam int OW    = cpra_pkg::OFF_W;
    localparam int XW    = cpra_pkg::WIDX_W;
    localparam int AWD   = cpra_pkg::ADDR_W;
    localparam int FW    = cpra_pkg::FIRST_W;
    localparam int DEPTH = (NUM_PAGES + cpra_pkg::WORD_BITS - 1) / cpra_pkg::WORD_BITS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cpra_pkg::t_state r_state, n_state;
    logic [AWD-1:0] r_base;
    logic [IW-1:0]  r_pages;
    logic [AW-1:0]  r_clr_addr, n_clr_addr;
    logic           r_pend, n_pend;
    logic           r_strobe, n_strobe;
    logic           r_ok, n_ok;
    logic [AWD-1:0] r_out_addr, n_out_addr;
    logic           r_set, n_set;
    logic [IW-1:0]  r_count, n_count;
    logic [IW-1:0]  r_lo, n_lo;
    logic [IW-1:0]  r_hi, n_hi;
    logic [IW-1:0]  r_run, n_run;
    logic [XW-1:0]  r_rd_widx, n_rd_widx;
    logic [XW-1:0]  r_proc_widx, n_proc_widx;
    logic [XW-1:0]  r_cur_widx, n_cur_widx;
    logic [FW-1:0]  r_first, n_first;

    logic [IW-1:0]  lim;
    logic [IW-1:0]  lim_m1;
    logic [IW-1:0]  hi_m1;
    logic [AWD-1:0] diff;
    logic [FW:0]    free_end;
    logic [W-1:0]   mask;
    logic [W-1:0]   rd_data;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [W-1:0]   ram_wdata;
    logic [AW-1:0]  ram_raddr;

    cpra_pkg::t_scan_res scan;

    // managed page count saturates at the store size
    assign lim    = (32'(r_pages) > NUM_PAGES) ? IW'(NUM_PAGES) : r_pages;
    assign lim_m1 = lim - IW'(1);
    assign hi_m1  = r_hi - IW'(1);
    assign diff   = i_address - r_base;
    assign free_end = (FW+1)'(r_first) + (FW+1)'(r_count);

    assign busy        = (r_state != cpra_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_strobe      = r_strobe;
    assign o_ok          = r_ok;
    assign o_run_address = r_out_addr;

    cpra_ram #(
        .WIDTH (W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    cpra_scan u_scan (
        .i_word  (rd_data),
        .i_widx  (r_proc_widx),
        .i_limit (lim),
        .i_count (r_count),
        .i_run   (r_run),
        .o_res   (scan)
    );

    // bits of the current word that fall inside the run being marked
    always_comb begin
        for (int b = 0; b < W; b++) begin
            mask[b] = ({r_cur_widx, OW'(b)} >= r_lo) && ({r_cur_widx, OW'(b)} < r_hi);
        end
    end

    // drive the bitmap RAM ports
    always_comb begin
        ram_raddr = (r_state == cpra_pkg::S_MARK_RD) ? AW'(r_cur_widx) : AW'(r_rd_widx);
        ram_we    = 1'b0;
        ram_waddr = AW'(r_cur_widx);
        ram_wdata = r_set ? (rd_data | mask) : (rd_data & ~mask);
        case (r_state)
            cpra_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
            end
            cpra_pkg::S_MARK_WR: begin
                ram_we = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // next state and datapath
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_pend      = r_pend;
        n_strobe    = 1'b0;
        n_ok        = r_ok;
        n_out_addr  = r_out_addr;
        n_set       = r_set;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_run       = r_run;
        n_rd_widx   = r_rd_widx;
        n_proc_widx = r_proc_widx;
        n_cur_widx  = r_cur_widx;
        n_first     = r_first;
        case (r_state)
            cpra_pkg::S_CLEAR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = cpra_pkg::S_IDLE;
                end
            end
            cpra_pkg::S_IDLE: begin
                if (start) begin
                    n_count = i_page_count;
                    n_set   = (i_op == cpra_pkg::OP_ALLOC);
                    if (i_op == cpra_pkg::OP_FREE) begin
                        n_first = diff[AWD-1:cpra_pkg::PAGE_SHIFT];
                        n_state = cpra_pkg::S_FREE;
                    end else if (i_page_count == '0 || i_page_count > lim) begin
                        n_strobe   = 1'b1;
                        n_ok       = 1'b0;
                        n_out_addr = '0;
                    end else begin
                        n_run     = '0;
                        n_rd_widx = '0;
                        n_pend    = 1'b0;
                        n_state   = cpra_pkg::S_SCAN;
                    end
                end
            end
            cpra_pkg::S_SCAN: begin
                // stream words out of the RAM, evaluate the one that arrived
                n_rd_widx   = r_rd_widx + XW'(1);
                n_proc_widx = r_rd_widx;
                n_pend      = 1'b1;
                if (r_pend) begin
                    if (scan.hit) begin
                        n_lo       = scan.start;
                        n_hi       = scan.start + r_count;
                        n_cur_widx = scan.start[IW-1:OW];
                        n_state    = cpra_pkg::S_MARK_RD;
                    end else if (r_proc_widx == lim_m1[IW-1:OW]) begin
                        n_strobe   = 1'b1;
                        n_ok       = 1'b0;
                        n_out_addr = '0;
                        n_state    = cpra_pkg::S_IDLE;
                    end else begin
                        n_run = scan.run;
                    end
                end
            end
            cpra_pkg::S_FREE: begin
                // clip the run to the managed range
                if (r_count == '0 || r_first >= FW'(lim)) begin
                    n_strobe   = 1'b1;
                    n_ok       = 1'b1;
                    n_out_addr = '0;
                    n_state    = cpra_pkg::S_IDLE;
                end else begin
                    n_lo       = r_first[IW-1:0];
                    n_hi       = (free_end >= (FW+1)'(lim)) ? lim : free_end[IW-1:0];
                    n_cur_widx = r_first[IW-1:OW];
                    n_state    = cpra_pkg::S_MARK_RD;
                end
            end
            cpra_pkg::S_MARK_RD: begin
                n_state = cpra_pkg::S_MARK_WR;
            end
            cpra_pkg::S_MARK_WR: begin
                if (r_cur_widx == hi_m1[IW-1:OW]) begin
                    n_strobe   = 1'b1;
                    n_ok       = 1'b1;
                    n_out_addr = r_set ? (r_base + (AWD'(r_lo) << cpra_pkg::PAGE_SHIFT)) : '0;
                    n_state    = cpra_pkg::S_IDLE;
                end else begin
                    n_cur_widx = r_cur_widx + XW'(1);
                    n_state    = cpra_pkg::S_MARK_RD;
                end
            end
            default: begin
                n_state = cpra_pkg::S_IDLE;
            end
        endcase
    end

    // control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= cpra_pkg::S_CLEAR;
            r_clr_addr <= '0;
            r_pend     <= 1'b0;
            r_strobe   <= 1'b0;
            r_base     <= cpra_pkg::BASE_RESET;
            r_pages    <= cpra_pkg::PAGES_RESET;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_pend     <= n_pend;
            r_strobe   <= n_strobe;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    cpra_pkg::CFG_BASE:  r_base  <= i_cfg_data;
                    cpra_pkg::CFG_PAGES: r_pages <= i_cfg_data[IW-1:0];
                    default: begin
                        r_base <= r_base;
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_ok        <= n_ok;
        r_out_addr  <= n_out_addr;
        r_set       <= n_set;
        r_count     <= n_count;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_run       <= n_run;
        r_rd_widx   <= n_rd_widx;
        r_proc_widx <= n_proc_widx;
        r_cur_widx  <= n_cur_widx;
        r_first     <= n_first;
    end

endmodule

FILE: sv/cpra_chk.sv
module cpra_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        i_op,
    input logic [cpra_pkg::IDX_W-1:0]  i_page_count,
    input logic                        o_strobe,
    input logic [cpra_pkg::ADDR_W-1:0] o_run_address,
    input logic                        o_ok
);

    // reset starts the bitmap clearing pass with no result out
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> busy && !o_strobe)
        else $error("block not busy clearing after reset");

    // a failed allocate always reports address zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_ok |-> o_run_address == '0)
        else $error("failed request with nonzero address");

    // a zero-count allocate fails on the next cycle
    a_zero_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_op == cpra_pkg::OP_ALLOC && i_page_count == '0
        |=> o_strobe && !o_ok)
        else $error("zero-count allocate did not fail at once");

    // a free always needs the range check cycle first
    a_free_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_op == cpra_pkg::OP_FREE |=> busy && !o_strobe)
        else $error("free answered without range check");

    // a result is only shown once the block is back to idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result shown while busy");

endmodule

bind contiguous_page_run_allocator cpra_chk u_cpra_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_op          (i_op),
    .i_page_count  (i_page_count),
    .o_strobe      (o_strobe),
    .o_run_address (o_run_address),
    .o_ok          (o_ok)
);

FILE: test/contiguous_page_run_allocator_tb.sv
module contiguous_page_run_allocator_tb;

    localparam int NUM_PAGES   = 4096;
    localparam int PAGE_BYTES  = 4096;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 64;
    localparam int MAX_COUNT   = 8191;

    typedef enum logic [1:0] {
        WORD_REQUEST,
        WORD_CONFIG,
        WORD_PAUSE
    } t_word_kind;

    typedef struct {
        t_word_kind                       kind;
        logic                             op;
        logic [cpra_pkg::IDX_W-1:0]       count;
        logic [cpra_pkg::ADDR_W-1:0]      address;
        bit                               live_free;
        int unsigned                      gap;
        logic [cpra_pkg::CFG_IDX_W-1:0]   cfg_index;
        logic [cpra_pkg::ADDR_W-1:0]      cfg_data;
    } t_pending_word;

    typedef struct packed {
        logic [cpra_pkg::ADDR_W-1:0] run_address;
        logic                        ok;
    } t_run_result;

    typedef struct {
        logic [cpra_pkg::ADDR_W-1:0] address;
        logic [cpra_pkg::IDX_W-1:0]  count;
    } t_live_run;

    logic                            i_clk;
    logic                            i_rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    logic                            i_op = 1'b0;
    logic [cpra_pkg::IDX_W-1:0]      i_page_count = '0;
    logic [cpra_pkg::ADDR_W-1:0]     i_address = '0;
    logic                            o_strobe;
    logic [cpra_pkg::ADDR_W-1:0]     o_run_address;
    logic                            o_ok;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [cpra_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [cpra_pkg::ADDR_W-1:0]     i_cfg_data = '0;

    // words waiting to be driven, predictions waiting for results
    t_pending_word pending_words[$];
    t_run_result   expected_runs[$];
    t_live_run     live_runs[$];

    // shadow of the allocator state
    bit                          page_used [NUM_PAGES];
    logic [cpra_pkg::ADDR_W-1:0] cfg_base  = cpra_pkg::BASE_RESET;
    logic [cpra_pkg::IDX_W-1:0]  cfg_pages = cpra_pkg::PAGES_RESET;

    logic        req_fire = 1'b0;
    logic        cfg_fire = 1'b0;
    int unsigned hold_cycles = 0;
    int unsigned stall_cycles = 0;
    int unsigned mismatch_count = 0;

    contiguous_page_run_allocator #(
        .NUM_PAGES(NUM_PAGES)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_page_count (i_page_count),
        .i_address    (i_address),
        .o_strobe     (o_strobe),
        .o_run_address(o_run_address),
        .o_ok         (o_ok),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what,
                                   input logic [cpra_pkg::ADDR_W-1:0] want,
                                   input logic [cpra_pkg::ADDR_W-1:0] got);
        mismatch_count++;
        $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
    endtask

    function automatic logic [cpra_pkg::ADDR_W-1:0] page_addr(
            input logic [cpra_pkg::ADDR_W-1:0] base, input int unsigned page);
        logic [cpra_pkg::ADDR_W-1:0] offset;
        offset = page;
        return base + (offset << cpra_pkg::PAGE_SHIFT);
    endfunction

    // first-fit search and bitmap update for one request
    task automatic predict_page_run(input logic op, input logic [cpra_pkg::IDX_W-1:0] count,
                                    input logic [cpra_pkg::ADDR_W-1:0] address,
                                    output t_run_result res);
        int unsigned limit;
        int unsigned run;
        int unsigned first_page;
        int unsigned i;
        int unsigned idx;
        logic [cpra_pkg::ADDR_W-1:0] offset;
        bit found;
        limit = (cfg_pages > NUM_PAGES) ? NUM_PAGES : cfg_pages;
        res = '0;
        run = 0;
        first_page = 0;
        found = 1'b0;
        if (op == cpra_pkg::OP_ALLOC) begin
            if (count != 0 && count <= limit) begin
                for (i = 0; i < limit && !found; i++) begin
                    if (page_used[i]) begin
                        run = 0;
                    end else begin
                        run++;
                        if (run == count) begin
                            found = 1'b1;
                            first_page = i + 1 - count;
                        end
                    end
                end
            end
            if (found) begin
                for (i = first_page; i < first_page + count; i++)
                    page_used[i] = 1'b1;
                res.run_address = page_addr(cfg_base, first_page);
                res.ok = 1'b1;
            end
        end else begin
            // wrap below base to a huge index, drop pages past the range
            offset = address - cfg_base;
            first_page = offset >> cpra_pkg::PAGE_SHIFT;
            for (i = 0; i < count; i++) begin
                idx = first_page + i;
                if (idx >= limit)
                    break;
                page_used[idx] = 1'b0;
            end
            res.ok = 1'b1;
        end
    endtask

    task automatic queue_request(input logic op, input int unsigned count,
                                 input logic [cpra_pkg::ADDR_W-1:0] address,
                                 input bit live_free, input int unsigned gap);
        t_pending_word w;
        w.kind      = WORD_REQUEST;
        w.op        = op;
        w.count     = count[cpra_pkg::IDX_W-1:0];
        w.address   = address;
        w.live_free = live_free;
        w.gap       = gap;
        w.cfg_index = '0;
        w.cfg_data  = '0;
        pending_words.push_back(w);
    endtask

    task automatic queue_config(input logic [cpra_pkg::CFG_IDX_W-1:0] index,
                                input logic [cpra_pkg::ADDR_W-1:0] data);
        t_pending_word w;
        w.kind      = WORD_CONFIG;
        w.op        = cpra_pkg::OP_ALLOC;
        w.count     = '0;
        w.address   = '0;
        w.live_free = 1'b0;
        w.gap       = 0;
        w.cfg_index = index;
        w.cfg_data  = data;
        pending_words.push_back(w);
    endtask

    task automatic queue_pause();
        t_pending_word w;
        w.kind      = WORD_PAUSE;
        w.op        = cpra_pkg::OP_ALLOC;
        w.count     = '0;
        w.address   = '0;
        w.live_free = 1'b0;
        w.gap       = 0;
        w.cfg_index = '0;
        w.cfg_data  = '0;
        pending_words.push_back(w);
    endtask

    // one configuration followed by a random mix of allocations, frees and pauses
    task automatic run_phase(input logic [cpra_pkg::ADDR_W-1:0] base,
                             input logic [cpra_pkg::ADDR_W-1:0] pages,
                             input int unsigned n_words, input bit calm);
        int unsigned limit;
        int unsigned short_max;
        int unsigned pick;
        int unsigned count;
        int unsigned gap;
        int unsigned j;
        logic [cpra_pkg::ADDR_W-1:0] address;
        queue_config(cpra_pkg::CFG_BASE, base);
        queue_config(cpra_pkg::CFG_PAGES, pages);
        limit = 32'(pages[cpra_pkg::IDX_W-1:0]);
        if (limit > NUM_PAGES)
            limit = NUM_PAGES;
        short_max = limit / 4;
        if (short_max > 32)
            short_max = 32;
        if (short_max == 0)
            short_max = 1;
        for (j = 0; j < n_words; j++) begin
            pick = $urandom_range(0, 99);
            gap = (!calm && $urandom_range(0, 99) < 13) ? $urandom_range(1, 40) : 0;
            address = $urandom;
            if (pick < 45) begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    count = $urandom_range(1, short_max);
                else if (pick < 88)
                    count = $urandom_range(1, (limit > 0) ? limit : 1);
                else if (pick < 94)
                    count = 0;
                else
                    count = $urandom_range(limit + 1, MAX_COUNT);
                queue_request(cpra_pkg::OP_ALLOC, count, address, 1'b0, gap);
            end else if (pick < 80) begin
                queue_request(cpra_pkg::OP_FREE, 0, '0, 1'b1, gap);
            end else if (pick < 98) begin
                if ($urandom_range(0, 1) != 0)
                    address = page_addr(base, $urandom_range(0, limit + 8))
                              + $urandom_range(0, PAGE_BYTES - 1);
                count = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 16)
                                                    : $urandom_range(0, MAX_COUNT);
                queue_request(cpra_pkg::OP_FREE, count, address, 1'b0, gap);
            end else begin
                queue_pause();
            end
        end
        if ($urandom_range(0, 1) != 0)
            queue_request(cpra_pkg::OP_FREE, MAX_COUNT, base, 1'b0, 0);
    endtask

    // drive one word at a time, hold it until the handshake takes it
    always @(negedge i_clk) begin
        t_pending_word w;
        logic next_start;
        logic next_cfg;
        int unsigned k;
        int unsigned part;
        next_start = start & ~req_fire;
        next_cfg = i_cfg_valid & ~cfg_fire;
        if (i_rst_n && !next_start && !next_cfg && pending_words.size() != 0) begin
            if (hold_cycles != 0) begin
                hold_cycles = hold_cycles - 1;
            end else begin
                w = pending_words[0];
                case (w.kind)
                    WORD_PAUSE: begin
                        if (expected_runs.size() == 0)
                            void'(pending_words.pop_front());
                    end
                    WORD_CONFIG: begin
                        if (expected_runs.size() == 0 && !busy) begin
                            void'(pending_words.pop_front());
                            next_cfg = 1'b1;
                            i_cfg_index <= w.cfg_index;
                            i_cfg_data <= w.cfg_data;
                        end
                    end
                    default: begin
                        void'(pending_words.pop_front());
                        // free a run still held, sometimes only part of it, or allocate 1 to 4 pages if none is held
                        if (w.live_free) begin
                            if (live_runs.size() != 0) begin
                                k = $urandom_range(0, live_runs.size() - 1);
                                w.address = live_runs[k].address
                                            + $urandom_range(0, PAGE_BYTES - 1);
                                w.count = live_runs[k].count;
                                if ($urandom_range(0, 7) == 0) begin
                                    part = $urandom_range(0, live_runs[k].count);
                                    w.count = part[cpra_pkg::IDX_W-1:0];
                                end
                                live_runs.delete(k);
                            end else begin
                                part = $urandom_range(1, 4);
                                w.op = cpra_pkg::OP_ALLOC;
                                w.count = part[cpra_pkg::IDX_W-1:0];
                            end
                        end
                        next_start = 1'b1;
                        i_op <= w.op;
                        i_page_count <= w.count;
                        i_address <= w.address;
                        hold_cycles = w.gap;
                    end
                endcase
            end
        end
        start <= next_start;
        i_cfg_valid <= next_cfg;
    end

    // check results, apply register writes, predict accepted requests
    always @(posedge i_clk) begin
        t_run_result res;
        t_run_result want;
        t_live_run held;
        if (!i_rst_n) begin
            req_fire <= 1'b0;
            cfg_fire <= 1'b0;
        end else begin
            if (o_strobe === 1'b1) begin
                if (expected_runs.size() == 0) begin
                    report_mismatch("result with nothing expected", '0, o_run_address);
                end else begin
                    want = expected_runs.pop_front();
                    if (o_run_address !== want.run_address)
                        report_mismatch("run_address", want.run_address, o_run_address);
                    if (o_ok !== want.ok)
                        report_mismatch("ok", {31'd0, want.ok}, {31'd0, o_ok});
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    cpra_pkg::CFG_BASE:  cfg_base = i_cfg_data;
                    cpra_pkg::CFG_PAGES: cfg_pages = i_cfg_data[cpra_pkg::IDX_W-1:0];
                    default: ;
                endcase
                live_runs.delete();
            end
            if (start && !busy) begin
                predict_page_run(i_op, i_page_count, i_address, res);
                expected_runs.push_back(res);
                if (i_op == cpra_pkg::OP_ALLOC && res.ok) begin
                    held.address = res.run_address;
                    held.count = i_page_count;
                    live_runs.push_back(held);
                end
            end
            req_fire <= start && !busy;
            cfg_fire <= i_cfg_valid && o_cfg_ready;
        end
    end

    // end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe === 1'b1
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        // zero counts, oversized counts, full and fragmented bitmap at reset settings
        queue_request(cpra_pkg::OP_ALLOC, 0, '0, 1'b0, 0);
        queue_request(cpra_pkg::OP_ALLOC, 1, 32'hFFFF_FFFF, 1'b0, 0);
        queue_request(cpra_pkg::OP_ALLOC, MAX_COUNT, '0, 1'b0, 0);
        queue_request(cpra_pkg::OP_ALLOC, NUM_PAGES, '0, 1'b0, 0);
        queue_request(cpra_pkg::OP_FREE, 0, cpra_pkg::BASE_RESET, 1'b0, 0);
        queue_request(cpra_pkg::OP_FREE, 1, cpra_pkg::BASE_RESET, 1'b0, 0);
        queue_request(cpra_pkg::OP_ALLOC, NUM_PAGES, '0, 1'b0, 0);
        queue_request(cpra_pkg::OP_ALLOC, 1, '0, 1'b0, 0);
        queue_request(cpra_pkg::OP_FREE, 5, page_addr(cpra_pkg::BASE_RESET, 100) + 32'hABC,
                      1'b0, 0);
        queue_request(cpra_pkg::OP_ALLOC, 6, '0, 1'b0, 0);
        queue_request(cpra_pkg::OP_ALLOC, 5, '0, 1'b0, 0);
        // addresses below base wrap far out of range
        queue_request(cpra_pkg::OP_FREE, MAX_COUNT, '0, 1'b0, 0);
        queue_request(cpra_pkg::OP_FREE, MAX_COUNT, 32'hFFFF_FFFF, 1'b0, 0);
        // free running past the last page
        queue_request(cpra_pkg::OP_FREE, 100, page_addr(cpra_pkg::BASE_RESET, 4090), 1'b0, 0);
        queue_request(cpra_pkg::OP_ALLOC, 7, '0, 1'b0, 0);
        queue_request(cpra_pkg::OP_ALLOC, 6, '0, 1'b0, 0);
        queue_request(cpra_pkg::OP_FREE, MAX_COUNT, cpra_pkg::BASE_RESET, 1'b0, 0);
        queue_request(cpra_pkg::OP_ALLOC, NUM_PAGES - 1, '0, 1'b0, 0);
        queue_request(cpra_pkg::OP_ALLOC, 2, '0, 1'b0, 0);
        queue_request(cpra_pkg::OP_ALLOC, 1, '0, 1'b0, 0);
        queue_request(cpra_pkg::OP_FREE, 3, page_addr(cpra_pkg::BASE_RESET, 7), 1'b0, 0);
        queue_request(cpra_pkg::OP_ALLOC, 3, '0, 1'b0, 0);

        // unaligned base near the top, oversized page count saturates
        queue_config(cpra_pkg::CFG_BASE, 32'hFFFF_E123);
        queue_config(cpra_pkg::CFG_PAGES, 32'hFFFF_FFFF);
        queue_request(cpra_pkg::OP_FREE, MAX_COUNT, 32'hFFFF_E123, 1'b0, 0);
        queue_request(cpra_pkg::OP_ALLOC, 2, '0, 1'b0, 0);
        queue_request(cpra_pkg::OP_ALLOC, 1, '0, 1'b0, 0);
        queue_request(cpra_pkg::OP_FREE, 1, 32'h0000_0123, 1'b0, 0);
        queue_request(cpra_pkg::OP_ALLOC, 1, '0, 1'b0, 0);

        run_phase(32'hFFFF_E123, 32'hFFFF_FFFF, 150, 1'b0);
        run_phase(32'h0000_0000, 32'd0, 30, 1'b0);
        run_phase(32'h0000_1000, 32'd1, 60, 1'b0);
        run_phase({20'($urandom_range(0, 32'hF_FFFF)), 12'h000}, 32'd8, 150, 1'b0);
        run_phase($urandom, 32'd37, 200, 1'b0);
        run_phase(cpra_pkg::BASE_RESET, 32'd4096, 400, 1'b1);
        run_phase(32'hFFFF_F000, 32'd4096, 200, 1'b0);
        run_phase($urandom, 32'd200, 300, 1'b0);
        run_phase($urandom, 32'd4095, 250, 1'b0);
        run_phase(32'h0000_0000, 32'd64, 200, 1'b0);

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every word to be taken, then for every result
        while (pending_words.size() != 0 || start || i_cfg_valid)
            @(posedge i_clk);
        while (expected_runs.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
